// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int PRIO_W = 8;
    localparam int HANDLE_W = 16;
    localparam int PATIENCE_W = 8;
    localparam int REQ_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PURGE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [HANDLE_W-1:0] handle;
        logic [PATIENCE_W-1:0] patience;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic insert;
        logic shift;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic full;
        logic empty;
        logic head_zero;
    } sts_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  spq_pkg::sts_t  sts,
    output spq_pkg::cmd_t  cmd
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.req_type == REQ_PURGE && sts.head_zero)
                begin
                    // drop one zero-patience head per cycle
                    cmd.shift = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                    case (sts.req_type)
                        REQ_INSERT: cmd.insert = !sts.full;
                        REQ_POP:    cmd.shift = !sts.empty;
                        default:    ;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spq_pkg::cmd_t                         cmd,
    output spq_pkg::sts_t                         sts,
    input  logic [spq_pkg::REQ_W-1:0]             req_type,
    input  logic [spq_pkg::PRIO_W-1:0]            priority_req,
    input  logic [spq_pkg::HANDLE_W-1:0]          payload_handle,
    input  logic [spq_pkg::PATIENCE_W-1:0]        patience,
    output logic [spq_pkg::STATUS_W-1:0]          status,
    output logic [spq_pkg::PRIO_W-1:0]            out_priority,
    output logic [spq_pkg::HANDLE_W-1:0]          out_handle,
    output logic [spq_pkg::PATIENCE_W-1:0]        out_patience,
    output logic [spq_pkg::COUNT_OUT_W-1:0]       entry_count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t cells_reg [DEPTH];
    entry_t cells_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [DEPTH-1:0] ge;

    logic [REQ_W-1:0] req_reg;
    entry_t new_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t out_entry_reg;
    entry_t out_entry_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    logic full;
    logic empty;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign sts.req_type = req_reg;
    assign sts.full = full;
    assign sts.empty = empty;
    assign sts.head_zero = !empty && (cells_reg[0].patience == '0);

    // cells holding a priority at least the new one stay put; ge is a prefix
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (count_reg > CNT_W'(i)) && (cells_reg[i].prio >= new_reg.prio);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (cmd.insert)
            begin
                if (!ge[i])
                begin
                    if (i == 0)
                        cells_next[i] = new_reg;
                    else if (ge[i-1])
                        cells_next[i] = new_reg;
                    else
                        cells_next[i] = cells_reg[i-1];
                end
            end
            else if (cmd.shift)
            begin
                if (i < DEPTH - 1)
                    cells_next[i] = cells_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.shift)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        status_next = STATUS_OK;
        out_entry_next = '0;
        case (req_reg)
            REQ_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
            end
            REQ_POP:
            begin
                if (empty)
                    status_next = STATUS_EMPTY;
                else
                    out_entry_next = cells_reg[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.load_req)
        begin
            req_reg <= req_type;
            new_reg.prio <= priority_req;
            new_reg.handle <= payload_handle;
            new_reg.patience <= patience;
        end
        if (cmd.load_out)
        begin
            status_reg <= status_next;
            out_entry_reg <= out_entry_next;
            out_count_reg <= count_next;
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, out_count_reg};

    assign status = status_reg;
    assign out_priority = out_entry_reg.prio;
    assign out_handle = out_entry_reg.handle;
    assign out_patience = out_entry_reg.patience;
    assign entry_count = count_ext[COUNT_OUT_W-1:0];

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Each accepted request word (insert, pop or other code) is registered; once the output
// slot is free, its result word is registered into the output. A purge first drops the
// zero-patience entries from the head, one at a time. The sorted cell row inserts or shifts
// all cells at once, and the controller takes a new word only when idle, after the last result.
// Reset (rst_n low, asynchronous) empties the queue and clears the output valid.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [spq_pkg::REQ_W-1:0]             req_type,
    input  logic [spq_pkg::PRIO_W-1:0]            priority_req,
    input  logic [spq_pkg::HANDLE_W-1:0]          payload_handle,
    input  logic [spq_pkg::PATIENCE_W-1:0]        patience,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [spq_pkg::STATUS_W-1:0]          status,
    output logic [spq_pkg::PRIO_W-1:0]            out_priority,
    output logic [spq_pkg::HANDLE_W-1:0]          out_handle,
    output logic [spq_pkg::PATIENCE_W-1:0]        out_patience,
    output logic [spq_pkg::COUNT_OUT_W-1:0]       entry_count
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .priority_req   (priority_req),
        .payload_handle (payload_handle),
        .patience       (patience),
        .status         (status),
        .out_priority   (out_priority),
        .out_handle     (out_handle),
        .out_patience   (out_patience),
        .entry_count    (entry_count)
    );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int RAND_WORDS = 1850;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT = 5000;
    // the package leaves code three unnamed; the block must ignore it
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0] req;
        entry_t           ent;
        bit               hold;
    } req_word_t;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        entry_t                 ent;
        logic [COUNT_OUT_W-1:0] count;
    } resp_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type = REQ_INSERT;
    logic [PRIO_W-1:0]     priority_req = '0;
    logic [HANDLE_W-1:0]   payload_handle = '0;
    logic [PATIENCE_W-1:0] patience = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [PRIO_W-1:0]     out_priority;
    logic [HANDLE_W-1:0]   out_handle;
    logic [PATIENCE_W-1:0] out_patience;
    logic [COUNT_OUT_W-1:0] entry_count;

    req_word_t  req_pending[$];
    resp_word_t resp_due[$];
    entry_t     shadow_q[$];

    bit in_took = 1'b0;
    bit quiet = 1'b0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_pct = 10;
    int stall_left = 0;
    int stall_pct = 10;

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .priority_req  (priority_req),
        .payload_handle(payload_handle),
        .patience      (patience),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_priority  (out_priority),
        .out_handle    (out_handle),
        .out_patience  (out_patience),
        .entry_count   (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // applies one request to the shadow queue and returns the word it should produce
    function automatic resp_word_t shadow_apply(logic [REQ_W-1:0] req, entry_t ent);
        resp_word_t r;
        int pos;
        r.status = STATUS_OK;
        r.ent = '0;
        case (req)
            REQ_INSERT:
            begin
                if (shadow_q.size() >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_q.size() && shadow_q[pos].prio >= ent.prio)
                        pos++;
                    shadow_q.insert(pos, ent);
                end
            end
            REQ_POP:
            begin
                if (shadow_q.size() == 0)
                    r.status = STATUS_EMPTY;
                else
                    r.ent = shadow_q.pop_front();
            end
            REQ_PURGE:
            begin
                while (shadow_q.size() > 0 && shadow_q[0].patience == '0)
                    void'(shadow_q.pop_front());
            end
            default: ;
        endcase
        r.count = COUNT_OUT_W'(shadow_q.size());
        return r;
    endfunction

    function automatic req_word_t mk_word(logic [REQ_W-1:0] req, int prio, int handle,
                                          int pat, bit hold);
        req_word_t w;
        w.req = req;
        w.ent.prio = PRIO_W'(prio);
        w.ent.handle = HANDLE_W'(handle);
        w.ent.patience = PATIENCE_W'(pat);
        w.hold = hold;
        return w;
    endfunction

    // four-state compare so an unknown output never slips through
    task automatic check_field(string name, logic [31:0] expv, logic [31:0] gotv);
        if (expv !== gotv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, gotv);
            mismatches++;
        end
    endtask

    // sender: holds a stalled word, otherwise picks the next one or idles
    always @(negedge clk)
    begin
        logic nxt_valid;
        req_word_t w;
        nxt_valid = 1'b0;
        if (rst_n && !(in_valid && !in_took))
        begin
            if (send_gap > 0 && !quiet)
                send_gap--;
            else if (req_pending.size() > 0)
            begin
                if (req_pending[0].hold && resp_due.size() != 0)
                    ;
                else if (!quiet && $urandom_range(0, 99) < send_pct)
                    send_gap = $urandom_range(1, 14) - 1;
                else
                begin
                    w = req_pending.pop_front();
                    nxt_valid = 1'b1;
                    req_type <= w.req;
                    priority_req <= w.ent.prio;
                    payload_handle <= w.ent.handle;
                    patience <= w.ent.patience;
                    if ($urandom_range(0, 63) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0: send_pct = 0;
                            1: send_pct = 10;
                            default: send_pct = 35;
                        endcase
                    end
                end
            end
            quiet = req_pending.size() < QUIET_TAIL;
            in_valid <= nxt_valid;
        end
    end

    // receiver: stalls in bursts
    always @(negedge clk)
    begin
        if ($urandom_range(0, 127) == 0)
        begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 35;
            endcase
        end
        if (stall_left > 0 && !quiet)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        entry_t ent;
        resp_word_t exp_w;
        bit out_took;
        in_took = rst_n && in_valid && !in_stall;
        out_took = rst_n && out_valid && !out_stall;
        if (in_took)
        begin
            ent.prio = priority_req;
            ent.handle = payload_handle;
            ent.patience = patience;
            resp_due.push_back(shadow_apply(req_type, ent));
        end
        if (out_took)
        begin
            if (resp_due.size() == 0)
            begin
                $error("result word with nothing expected: status %0d count %0d",
                       status, entry_count);
                mismatches++;
            end
            else
            begin
                exp_w = resp_due.pop_front();
                check_field("status", exp_w.status, status);
                check_field("out_priority", exp_w.ent.prio, out_priority);
                check_field("out_handle", exp_w.ent.handle, out_handle);
                check_field("out_patience", exp_w.ent.patience, out_patience);
                check_field("entry_count", exp_w.count, entry_count);
            end
        end
        if (in_took || out_took)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int mix;
        int phase_left;
        int zero_pct;
        int ins_pct;
        int pop_pct;
        int roll;
        int prio;
        int pat;
        logic [REQ_W-1:0] req;

        // empty queue corner cases
        req_pending.push_back(mk_word(REQ_POP, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_PURGE, 255, 65535, 255, 1'b0));
        req_pending.push_back(mk_word(REQ_UNUSED, 255, 65535, 255, 1'b0));
        // ordering: ties keep arrival order, 150 lands behind the 200 head
        req_pending.push_back(mk_word(REQ_INSERT, 200, 16'h1234, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_INSERT, 100, 16'h00ff, 5, 1'b0));
        req_pending.push_back(mk_word(REQ_INSERT, 150, 16'hff00, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_INSERT, 200, 16'h5a5a, 7, 1'b0));
        req_pending.push_back(mk_word(REQ_INSERT, 255, 65535, 255, 1'b0));
        req_pending.push_back(mk_word(REQ_INSERT, 0, 0, 0, 1'b0));
        // head patience nonzero: purge removes nothing
        req_pending.push_back(mk_word(REQ_PURGE, 0, 0, 0, 1'b1));
        req_pending.push_back(mk_word(REQ_POP, 17, 99, 3, 1'b0));
        req_pending.push_back(mk_word(REQ_PURGE, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_POP, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_PURGE, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_UNUSED, 85, 16'haaaa, 170, 1'b0));
        req_pending.push_back(mk_word(REQ_POP, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_POP, 0, 0, 0, 1'b0));
        req_pending.push_back(mk_word(REQ_POP, 0, 0, 0, 1'b0));

        // random part in phases that push the fill level up, down or hold it
        phase_left = 0;
        mix = 0;
        zero_pct = 30;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                mix = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
                zero_pct = $urandom_range(10, 90);
            end
            phase_left--;
            case (mix)
                0:
                begin
                    ins_pct = 70;
                    pop_pct = 15;
                end
                1:
                begin
                    ins_pct = 20;
                    pop_pct = 60;
                end
                default:
                begin
                    ins_pct = 45;
                    pop_pct = 35;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                req = REQ_INSERT;
            else if (roll < ins_pct + pop_pct)
                req = REQ_POP;
            else if (roll < 98)
                req = REQ_PURGE;
            else
                req = REQ_UNUSED;
            // coarse priorities half the time so ties are common
            if ($urandom_range(0, 1) == 0)
                prio = $urandom_range(0, 255);
            else
                prio = $urandom_range(0, 7) * 36;
            pat = ($urandom_range(0, 99) < zero_pct) ? 0 : $urandom_range(1, 255);
            req_pending.push_back(mk_word(req, prio, $urandom_range(0, 65535), pat,
                                          n == RAND_WORDS / 2));
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (req_pending.size() != 0 || in_valid || resp_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
bench/tb_top.sv
